/* src/drf_pkg.sv */
// shared types, codes and defaults for the duplicate read filter
package drf_pkg;

  localparam int MAX_CHROMS_DEF = 4;
  localparam int POSITIONS_DEF  = 16384;
  localparam int COUNT_BITS_DEF = 16;

  // widths fixed by the item layout
  localparam int CMD_W    = 2;
  localparam int FLAG_W   = 12;
  localparam int CHROM_W  = 2;
  localparam int START_W  = 14;
  localparam int RND_W    = 31;
  localparam int OCOUNT_W = 16;
  localparam int CIU_W    = 3;
  localparam int STEP_W   = 5;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CMD_W-1:0] CMD_COUNT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESOLVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

  localparam logic [FLAG_W-1:0] PAIR_FLAG_A = 12'd99;
  localparam logic [FLAG_W-1:0] PAIR_FLAG_B = 12'd83;

  localparam logic             CFG_IDX_CHROMS = 1'b0;
  localparam logic [CIU_W-1:0] CHROMS_RESET   = 3'd4;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_CHROM = 1'b1;

  // command to the shared remainder unit
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } drf_mod_ctl_t;

endpackage

/* src/drf_mod_unit.sv */
// shared restoring remainder unit, one dividend bit per cycle
module drf_mod_unit import drf_pkg::*; #(
  parameter int DIV_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  drf_mod_ctl_t     ctl,
  input  logic [RND_W-1:0] dividend,   // left aligned, msb first
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] remainder
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_cnt_r;
  logic [RND_W-1:0]  dvd_r;
  logic [DIV_W-1:0]  dvs_r;
  logic [DIV_W-1:0]  rem_r;

  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic [DIV_W-1:0] rem_step;

  always_comb begin
    trial = {rem_r, dvd_r[RND_W-1]};
    diff  = trial - {1'b0, dvs_r};
    // remainder stays below the divisor, so the difference fits
    if (trial >= {1'b0, dvs_r}) begin
      rem_step = diff[DIV_W-1:0];
    end else begin
      rem_step = trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      done_r     <= 1'b0;
      step_cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r     <= 1'b1;
        step_cnt_r <= ctl.steps;
      end else if (busy_r) begin
        step_cnt_r <= step_cnt_r - STEP_W'(1);
        if (step_cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[RND_W-2:0], 1'b0};
      rem_r <= rem_step;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

/* src/duplicate_read_filter_unit.sv */
// duplicate read filter: counter tables with count, resolve and query commands
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+---------------------------------------
//  in_     | in  | in_tvalid/in_tready   | tuser command, tdata read fields
//  out_    | out | out_tvalid/out_tready | tuser status, tdata keep, count_value
//  cfg_    | in  | apb, pready always 1  | chroms_in_use at byte address 0
//
// count and query pass through the read, calc and result states; the counter result
// is registered in calc. an out of range chromosome skips the memory and goes straight
// to the result state. resolve on a count above one adds a pass through the shared
// remainder unit (31 bit steps). with a position count below 16384 that is not a
// power of two, every in range item first takes a position remainder on that unit.
// after reset the counter memory, 4 << (chrom bits + position bits) entries (262144
// by default), is cleared one entry a cycle, and no item is taken meanwhile.
// a result waits in the output register; the next item is taken while it waits.
module duplicate_read_filter_unit import drf_pkg::*; #(
  parameter int MAX_CHROMS = MAX_CHROMS_DEF,
  parameter int POSITIONS  = POSITIONS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_tvalid,
  output logic                   in_tready,
  // sam_flag[11:0], reverse_strand[12], chrom_index[14:13], start_first[28:15],
  // start_second[42:29], random_word[73:43], zero[79:74]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // command[1:0]
  input  logic [CMD_W-1:0]       in_tuser,

  output logic                   out_tvalid,
  input  logic                   out_tready,
  // keep[0], count_value[16:1], zero[23:17]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // status[0]
  output logic                   out_tuser,

  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  localparam int CBITS  = (MAX_CHROMS > 1) ? $clog2(MAX_CHROMS) : 1;
  localparam int POS_W  = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int ADDR_W = 2 + CBITS + POS_W;
  localparam logic NEED_POS_MOD = (POSITIONS < (1 << START_W)) &&
                                  ((POSITIONS & (POSITIONS - 1)) != 0);
  localparam int DIV_W = (COUNT_BITS > START_W) ? COUNT_BITS : START_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_POSMOD = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_CALC   = 3'd4;
  localparam logic [2:0] S_RESMOD = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0] state_r, state_nxt;

  logic [COUNT_BITS-1:0] mem [0:(64'(1) << ADDR_W) - 1];

  logic [ADDR_W-1:0]     clr_addr_r;
  logic [CIU_W-1:0]      chroms_r;
  logic [CMD_W-1:0]      cmd_r;
  logic [1:0]            tbl_r;
  logic [CBITS-1:0]      chrom_r;
  logic [POS_W-1:0]      pos_r;
  logic [RND_W-1:0]      rnd_r;
  logic [COUNT_BITS-1:0] rdata_r;
  logic                  res_keep_r;
  logic [COUNT_BITS-1:0] res_cnt_r;
  logic                  res_status_r;
  logic                  out_valid_r;
  logic                  out_keep_r;
  logic [OCOUNT_W-1:0]   out_count_r;
  logic                  out_status_r;

  // input fields
  logic [FLAG_W-1:0]  in_flag;
  logic               in_rev;
  logic [CHROM_W-1:0] in_chrom;
  logic [START_W-1:0] in_s1;
  logic [START_W-1:0] in_s2;
  logic [RND_W-1:0]   in_rnd;
  logic               paired;
  logic [START_W-1:0] pos_sel;
  logic               range_ok;
  logic               accept;

  logic [ADDR_W-1:0]     item_addr;
  logic [ADDR_W-1:0]     mem_addr;
  logic                  mem_we;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic                  mem_re;

  logic [COUNT_BITS-1:0] calc_cnt;
  logic                  calc_keep;
  logic                  need_mod;
  logic [COUNT_BITS-1:0] resolved_cnt;

  drf_mod_ctl_t      mod_ctl;
  logic [RND_W-1:0]  mod_dividend;
  logic [DIV_W-1:0]  mod_divisor;
  logic              mod_done;
  logic [DIV_W-1:0]  mod_rem;

  logic cfg_wr;

  assign in_flag  = in_tdata[11:0];
  assign in_rev   = in_tdata[12];
  assign in_chrom = in_tdata[14:13];
  assign in_s1    = in_tdata[28:15];
  assign in_s2    = in_tdata[42:29];
  assign in_rnd   = in_tdata[73:43];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign paired   = (in_flag == PAIR_FLAG_A) || (in_flag == PAIR_FLAG_B);
  assign pos_sel  = (paired && (in_s2 < in_s1)) ? in_s2 : in_s1;
  assign range_ok = ({1'b0, in_chrom} < chroms_r) && (32'(in_chrom) < MAX_CHROMS);

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_CHROMS) ? CFG_DATA_W'(chroms_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chroms_r <= CHROMS_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == CFG_IDX_CHROMS)) begin
      chroms_r <= cfg_pwdata[CIU_W-1:0];
    end
  end

  // counter update for the item read from memory
  always_comb begin
    calc_cnt  = rdata_r;
    calc_keep = 1'b0;
    need_mod  = 1'b0;
    unique case (cmd_r)
      CMD_COUNT: begin
        if (rdata_r != COUNT_MAX) begin
          calc_cnt = rdata_r + COUNT_BITS'(1);
        end
      end
      CMD_RESOLVE: begin
        need_mod = (rdata_r > COUNT_BITS'(1));
      end
      CMD_QUERY: begin
        if (rdata_r != '0) begin
          calc_cnt  = rdata_r - COUNT_BITS'(1);
          calc_keep = (rdata_r == COUNT_BITS'(1));
        end
      end
      default: begin
        calc_cnt = rdata_r;
      end
    endcase
  end

  assign resolved_cnt = COUNT_BITS'(mod_rem) + COUNT_BITS'(1);

  // shared remainder unit: position wrap at accept, resolve in calc
  always_comb begin
    mod_ctl.start = (accept && range_ok && NEED_POS_MOD) ||
                    ((state_r == S_CALC) && need_mod);
    if (state_r == S_IDLE) begin
      mod_ctl.steps = STEP_W'(START_W);
      mod_dividend  = {pos_sel, {(RND_W - START_W){1'b0}}};
      mod_divisor   = DIV_W'(POSITIONS);
    end else begin
      mod_ctl.steps = STEP_W'(RND_W);
      mod_dividend  = rnd_r;
      mod_divisor   = DIV_W'(rdata_r);
    end
  end

  drf_mod_unit #(
    .DIV_W (DIV_W)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mod_ctl),
    .dividend  (mod_dividend),
    .divisor   (mod_divisor),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // counter memory
  assign item_addr = {tbl_r, chrom_r, pos_r};
  assign mem_addr  = (state_r == S_CLEAR) ? clr_addr_r : item_addr;
  assign mem_re    = (state_r == S_READ);

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = calc_cnt;
    priority case (1'b1)
      (state_r == S_CLEAR): begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      (state_r == S_CALC): begin
        mem_we = !need_mod;
      end
      (state_r == S_RESMOD): begin
        mem_we    = mod_done;
        mem_wdata = resolved_cnt;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == {ADDR_W{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (!range_ok) begin
            state_nxt = S_RESULT;
          end else if (NEED_POS_MOD) begin
            state_nxt = S_POSMOD;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_POSMOD: begin
        if (mod_done) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CALC;
      end
      S_CALC: begin
        state_nxt = need_mod ? S_RESMOD : S_RESULT;
      end
      S_RESMOD: begin
        if (mod_done) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if ((state_r == S_RESULT) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r        <= in_tuser;
      tbl_r        <= {!paired, in_rev};
      chrom_r      <= CBITS'(in_chrom);
      pos_r        <= POS_W'(pos_sel);
      rnd_r        <= in_rnd;
      res_keep_r   <= 1'b0;
      res_cnt_r    <= '0;
      res_status_r <= range_ok ? STATUS_OK : STATUS_BAD_CHROM;
    end
    if ((state_r == S_POSMOD) && mod_done) begin
      pos_r <= POS_W'(mod_rem);
    end
    if ((state_r == S_CALC) && !need_mod) begin
      res_keep_r <= calc_keep;
      res_cnt_r  <= calc_cnt;
    end
    if ((state_r == S_RESMOD) && mod_done) begin
      res_cnt_r <= resolved_cnt;
    end
    if ((state_r == S_RESULT) && (!out_valid_r || out_tready)) begin
      out_keep_r   <= res_keep_r;
      out_count_r  <= OCOUNT_W'(res_cnt_r);
      out_status_r <= res_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - OCOUNT_W - 1){1'b0}}, out_count_r, out_keep_r};
  assign out_tuser  = out_status_r;

endmodule

/* tb/sv/duplicate_read_filter_unit_tb.sv */
// self-checking testbench for the duplicate read filter unit
module duplicate_read_filter_unit_tb;
  import drf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0]      CMD_UNUSED  = 2'd3;
  localparam int unsigned           COUNT_MAX   = (1 << COUNT_BITS_DEF) - 1;
  localparam logic [CFG_ADDR_W-1:0] CHROMS_ADDR = CFG_ADDR_W'({CFG_IDX_CHROMS, 2'b00});
  localparam logic [RND_W-1:0]      RND_MAX     = '1;
  localparam logic [START_W-1:0]    START_MAX   = '1;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [FLAG_W-1:0]  flag;
    logic               rev;
    logic [CHROM_W-1:0] chrom;
    logic [START_W-1:0] s1;
    logic [START_W-1:0] s2;
    logic [RND_W-1:0]   rnd;
  } read_item_t;

  typedef struct packed {
    logic                keep;
    logic [OCOUNT_W-1:0] count_value;
    logic                status;
  } read_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // sam_flag, reverse_strand, chrom_index, start_first, start_second, random_word, zero
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  // command
  logic [CMD_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // keep, count_value, zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  // status
  logic                   out_tuser;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  duplicate_read_filter_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // predictor state: sparse copy of the counter tables and the chromosome limit
  int unsigned      dup_count [int unsigned];
  logic [CIU_W-1:0] chroms_cfg = CHROMS_RESET;

  read_item_t   pending_reads[$];
  read_result_t expected_counts[$];
  read_item_t   on_bus;
  int pushed = 0;
  int accepted = 0;
  int results_seen = 0;
  int mismatches = 0;
  int kept_seen = 0;
  int bad_chrom_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold = 0;

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  function automatic read_result_t apply_read(input read_item_t it);
    read_result_t r;
    logic [1:0] tbl;
    logic [START_W-1:0] pos;
    int unsigned key;
    int unsigned cnt;
    r = '0;
    if (it.chrom >= chroms_cfg || it.chrom >= MAX_CHROMS_DEF) begin
      r.status = STATUS_BAD_CHROM;
      return r;
    end
    if (it.flag == PAIR_FLAG_A || it.flag == PAIR_FLAG_B) begin
      // pairs are keyed by the leftmost mate
      tbl = {1'b0, it.rev};
      pos = (it.s2 < it.s1) ? it.s2 : it.s1;
    end else begin
      tbl = {1'b1, it.rev};
      pos = it.s1;
    end
    key = 32'({tbl, it.chrom, pos});
    cnt = dup_count.exists(key) ? dup_count[key] : 0;
    case (it.cmd)
      CMD_COUNT:   if (cnt < COUNT_MAX) cnt++;
      CMD_RESOLVE: if (cnt > 1) cnt = (it.rnd % cnt) + 1;
      CMD_QUERY: begin
        if (cnt > 0) begin
          cnt--;
          if (cnt == 0) r.keep = 1'b1;
        end
      end
      default: ;
    endcase
    dup_count[key] = cnt;
    r.count_value = cnt[OCOUNT_W-1:0];
    r.status = STATUS_OK;
    return r;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_counts.insert(expected_counts.size(), apply_read(on_bus));
        accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reads.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = pending_reads.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= IN_TDATA_W'({on_bus.rnd, on_bus.s2, on_bus.s1, on_bus.chrom,
                                   on_bus.rev, on_bus.flag});
          in_tuser <= on_bus.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver, with an optional long hold-off counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    read_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_counts.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = expected_counts.pop_front();
        if (out_tdata[0] !== want.keep)
          report_mismatch($sformatf("result %0d keep %b, expected %b",
                                    results_seen, out_tdata[0], want.keep));
        if (out_tdata[OCOUNT_W:1] !== want.count_value)
          report_mismatch($sformatf("result %0d count %0d, expected %0d",
                                    results_seen, out_tdata[OCOUNT_W:1], want.count_value));
        if (out_tuser !== want.status)
          report_mismatch($sformatf("result %0d status %b, expected %b",
                                    results_seen, out_tuser, want.status));
        if (want.keep) kept_seen++;
        if (want.status == STATUS_BAD_CHROM) bad_chrom_seen++;
      end
      results_seen++;
    end
  end

  task automatic push_read(input read_item_t it);
    pending_reads.insert(pending_reads.size(), it);
    pushed++;
  endtask

  function automatic read_item_t mk(input logic [CMD_W-1:0] c, input logic [FLAG_W-1:0] f,
                                    input logic r, input logic [CHROM_W-1:0] ch,
                                    input logic [START_W-1:0] a, input logic [START_W-1:0] b,
                                    input logic [RND_W-1:0] rw);
    read_item_t it;
    it.cmd = c; it.flag = f; it.rev = r; it.chrom = ch; it.s1 = a; it.s2 = b; it.rnd = rw;
    return it;
  endfunction

  // mostly a small set of starts so that reads collide
  function automatic logic [START_W-1:0] pick_start();
    if ($urandom_range(3) == 0) return START_W'($urandom_range(16383));
    case ($urandom_range(7))
      0: return 0;
      1: return 1;
      2: return 100;
      3: return 5000;
      4: return 8191;
      5: return 8192;
      6: return 16382;
      default: return START_MAX;
    endcase
  endfunction

  function automatic logic [FLAG_W-1:0] single_flag();
    logic [FLAG_W-1:0] f;
    f = FLAG_W'($urandom);
    while (f == PAIR_FLAG_A || f == PAIR_FLAG_B) f = FLAG_W'($urandom);
    return f;
  endfunction

  function automatic read_item_t random_read();
    read_item_t it;
    int pick;
    pick = $urandom_range(99);
    it.cmd = (pick < 40) ? CMD_COUNT : (pick < 55) ? CMD_RESOLVE :
             (pick < 95) ? CMD_QUERY : CMD_UNUSED;
    case ($urandom_range(9))
      0, 1:    it.flag = PAIR_FLAG_A;
      2, 3:    it.flag = PAIR_FLAG_B;
      // one bit away from a pair flag
      4:       it.flag = ($urandom_range(1) ? PAIR_FLAG_A : PAIR_FLAG_B)
                         ^ (FLAG_W'(1) << $urandom_range(FLAG_W - 1));
      default: it.flag = FLAG_W'($urandom);
    endcase
    it.rev = 1'($urandom_range(1));
    it.chrom = CHROM_W'($urandom_range(3));
    it.s1 = pick_start();
    it.s2 = pick_start();
    it.rnd = RND_W'($urandom);
    return it;
  endfunction

  // copies of one read counted, maybe resolved, then queried down past zero
  task automatic push_dup_group();
    read_item_t base, it;
    logic paired;
    int n;
    base = random_read();
    paired = 1'($urandom_range(1));
    base.flag = paired ? ($urandom_range(1) ? PAIR_FLAG_A : PAIR_FLAG_B) : single_flag();
    base.cmd = CMD_COUNT;
    n = $urandom_range(1, 6);
    repeat (n) begin
      it = base;
      it.rnd = RND_W'($urandom);
      if (paired && $urandom_range(1)) begin
        it.s1 = base.s2;
        it.s2 = base.s1;
        it.flag = $urandom_range(1) ? PAIR_FLAG_A : PAIR_FLAG_B;
      end else if (!paired) begin
        it.s2 = START_W'($urandom);
      end
      push_read(it);
    end
    if ($urandom_range(9) < 7) begin
      it = base;
      it.cmd = CMD_RESOLVE;
      it.rnd = RND_W'($urandom);
      push_read(it);
    end
    repeat (n + 1) begin
      it = base;
      it.cmd = CMD_QUERY;
      push_read(it);
    end
  endtask

  task automatic random_reads(input int n);
    int stop;
    stop = pushed + n;
    while (pushed < stop) begin
      if ($urandom_range(99) < 65) push_dup_group();
      else push_read(random_read());
    end
  endtask

  // wait until every read went in and every result came back
  task automatic drain();
    while (accepted != pushed || expected_counts.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic check_chroms(input logic [CIU_W-1:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_paddr <= CHROMS_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== CFG_DATA_W'(val))
      report_mismatch($sformatf("chroms_in_use reads %0d, expected %0d", cfg_prdata, val));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic write_chroms(input logic [CIU_W-1:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= CHROMS_ADDR;
    cfg_pwdata <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    chroms_cfg = val;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    check_chroms(val);
    @(negedge clk);
  endtask

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 14;
    recv_idle_pct = 60;
    // paired forward: both mates orders and both pair flags land on the leftmost start
    push_read(mk(CMD_COUNT,   PAIR_FLAG_A, 0, 0, 200, 100, 0));
    push_read(mk(CMD_COUNT,   PAIR_FLAG_B, 0, 0, 100, 300, RND_MAX));
    push_read(mk(CMD_COUNT,   PAIR_FLAG_A, 1, 3, START_MAX, START_MAX, 0));
    push_read(mk(CMD_COUNT,   12'd0,       0, 2, START_MAX, 0, 0));
    push_read(mk(CMD_COUNT,   12'hFFF,     1, 1, 0, START_MAX, RND_MAX));
    push_read(mk(CMD_COUNT,   12'd98,      0, 0, 100, 100, 0));
    // resolve on zero, on one and on two
    push_read(mk(CMD_RESOLVE, 12'd0,       1, 0, 777, 0, RND_MAX));
    push_read(mk(CMD_RESOLVE, 12'd0,       0, 2, START_MAX, 5, RND_MAX));
    push_read(mk(CMD_RESOLVE, PAIR_FLAG_A, 0, 0, 100, 100, RND_MAX));
    // query on an empty counter, then down to zero and once more
    push_read(mk(CMD_QUERY,   12'd0,       0, 3, 42, 0, 0));
    push_read(mk(CMD_QUERY,   PAIR_FLAG_B, 0, 0, 150, 100, 0));
    push_read(mk(CMD_QUERY,   PAIR_FLAG_A, 0, 0, 100, 9000, 0));
    push_read(mk(CMD_QUERY,   PAIR_FLAG_A, 0, 0, 100, 100, 0));
    push_read(mk(CMD_UNUSED,  PAIR_FLAG_B, 1, 3, START_MAX, START_MAX, RND_MAX));
    push_read(mk(CMD_QUERY,   PAIR_FLAG_A, 1, 3, START_MAX, START_MAX, 0));
    repeat (3) push_read(mk(CMD_COUNT, 12'd7, 1, 2, 8192, 0, 0));
    push_read(mk(CMD_RESOLVE, 12'd7,       1, 2, 8192, 0, 0));
    push_read(mk(CMD_QUERY,   12'd7,       1, 2, 8192, 0, 0));
    drain();
    check_chroms(CHROMS_RESET);

    write_chroms(3'd1);
    push_read(mk(CMD_COUNT,   12'd0, 0, 1, 10, 0, 0));
    push_read(mk(CMD_QUERY,   12'd0, 0, 3, 10, 0, 0));
    push_read(mk(CMD_COUNT,   12'd0, 0, 0, 10, 0, 0));
    random_reads(540);
    // hold the output back while reads keep coming so the block backs up
    recv_hold = 400;
    drain();

    write_chroms(3'd0);
    random_reads(30);
    drain();
    write_chroms(3'd7);
    random_reads(60);
    drain();

    send_idle_pct = 60;
    recv_idle_pct = 14;
    write_chroms(3'd2);
    random_reads(540);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_chroms(CHROMS_RESET);
    // pile up one counter back to back, then poke it with the other commands
    repeat (40) push_read(mk(CMD_COUNT, 12'd0, 0, 1, 12345, 0, 0));
    push_read(mk(CMD_UNUSED,  12'd0, 0, 1, 12345, 0, 0));
    push_read(mk(CMD_RESOLVE, 12'd0, 0, 1, 12345, 0, RND_MAX));
    push_read(mk(CMD_QUERY,   12'd0, 0, 1, 12345, 0, 0));
    drain();
    write_chroms(3'd3);
    random_reads(540);
    drain();

    if (expected_counts.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_counts.size()));
    $display("%0d reads checked across chromosome limits 0 to 7 under three stall patterns",
             results_seen);
    $display("%0d kept, %0d out of range", kept_seen, bad_chrom_seen);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
